// ----- design/roc_pkg.sv -----
package roc_pkg;

    // Field widths and arithmetic constants
    localparam int CHAN_W             = 8;
    localparam int CFG_INDEX_W        = 1;
    localparam int CFG_DATA_W         = 8;
    localparam int DIV_STAGES         = 4;
    localparam int DIV_BITS_PER_STAGE = 2;

    localparam logic [7:0]  OPAQUE_ALPHA = 8'd255;
    localparam logic [15:0] ROUND_HALF   = 16'h0080;
    localparam logic [8:0]  RATIO_ONE    = 9'd256;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_HAS_ALPHA = 1'd0,
        CFG_GLOBAL_OPACITY   = 1'd1
    } cfg_index_t;

    // Color selection decided before the blend sums
    typedef enum logic [1:0] {
        CASE_ZERO_ALPHA = 2'd0,
        CASE_COPY_SRC   = 2'd1,
        CASE_KEEP_DEST  = 2'd2,
        CASE_BLEND      = 2'd3
    } blend_case_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic              has_alpha;
        logic [CHAN_W-1:0] opacity;
    } cfg_t;

    typedef struct packed {
        rgb_t              dest;
        logic [CHAN_W-1:0] dest_alpha;
        rgb_t              source;
        logic [CHAN_W-1:0] source_alpha;
    } in_item_t;

    // Pixel after source and output alpha are known
    typedef struct packed {
        rgb_t              dest;
        rgb_t              source;
        logic [CHAN_W-1:0] sa;
        logic [CHAN_W-1:0] alpha;
    } comp_item_t;

    typedef struct packed {
        comp_item_t        base;
        logic [CHAN_W-1:0] ratio;
    } ratio_item_t;

    typedef struct packed {
        rgb_t              color;
        logic [CHAN_W-1:0] alpha;
    } out_item_t;

endpackage

// ----- design/roc_if.sv -----
// Input pixel pair channel
interface roc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] dest_red;
    logic [7:0] dest_green;
    logic [7:0] dest_blue;
    logic [7:0] dest_alpha;
    logic [7:0] source_red;
    logic [7:0] source_green;
    logic [7:0] source_blue;
    logic [7:0] source_alpha;

    modport source (
        output valid, dest_red, dest_green, dest_blue, dest_alpha,
               source_red, source_green, source_blue, source_alpha,
        input  ready
    );
    modport sink (
        input  valid, dest_red, dest_green, dest_blue, dest_alpha,
               source_red, source_green, source_blue, source_alpha,
        output ready
    );
endinterface

// Composited pixel channel
interface roc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_red;
    logic [7:0] result_green;
    logic [7:0] result_blue;
    logic [7:0] result_alpha;

    modport source (
        output valid, result_red, result_green, result_blue, result_alpha,
        input  ready
    );
    modport sink (
        input  valid, result_red, result_green, result_blue, result_alpha,
        output ready
    );
endinterface

// ----- design/roc_alpha.sv -----
// Source alpha scaling and output alpha, four stages
module roc_alpha import roc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output comp_item_t out_item
);

    // Rounded divide by 255 of a product that already holds the half term
    function automatic logic [7:0] div255(input logic [15:0] t);
        logic [16:0] s;
        s = {9'd0, t[15:8]} + {1'b0, t};
        return s[15:8];
    endfunction

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic        s1_ready, s2_ready, s3_ready, s4_ready;

    comp_item_t  s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    logic [7:0]  s1_da_reg, s2_da_reg;
    logic [15:0] s1_prod_reg, s3_prod_reg;
    logic        s1_bypass_reg;

    logic [7:0]  sa_eff;
    logic [15:0] s1_prod_next;
    logic [7:0]  s2_sa_next;
    logic [15:0] s3_prod_next;
    logic [7:0]  s4_alpha_next;
    comp_item_t  s2_item_next, s4_item_next;

    // Ready ripples back from the output; a stage moves when empty or draining
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage math
    always_comb
    begin
        sa_eff        = cfg.has_alpha ? in_item.source_alpha : OPAQUE_ALPHA;
        s1_prod_next  = {8'd0, sa_eff} * {8'd0, cfg.opacity} + ROUND_HALF;
        s2_sa_next    = s1_bypass_reg ? s1_item_reg.sa : div255(s1_prod_reg);
        s3_prod_next  = {8'd0, s2_da_reg} * {8'd0, OPAQUE_ALPHA - s2_item_reg.sa}
                        + ROUND_HALF;
        s4_alpha_next = s3_item_reg.sa + div255(s3_prod_reg);

        s2_item_next       = s1_item_reg;
        s2_item_next.sa    = s2_sa_next;
        s4_item_next       = s3_item_reg;
        s4_item_next.alpha = s4_alpha_next;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_item_reg.dest   <= in_item.dest;
            s1_item_reg.source <= in_item.source;
            s1_item_reg.sa     <= sa_eff;
            s1_item_reg.alpha  <= '0;
            s1_da_reg          <= in_item.dest_alpha;
            s1_prod_reg        <= s1_prod_next;
            s1_bypass_reg      <= (cfg.opacity == OPAQUE_ALPHA);
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg <= s2_item_next;
            s2_da_reg   <= s1_da_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_item_reg <= s2_item_reg;
            s3_prod_reg <= s3_prod_next;
        end
        if (s4_ready && s3_valid_reg)
            s4_item_reg <= s4_item_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

endmodule

// ----- design/roc_div.sv -----
// Pipelined restoring divider: ratio = (sa << 8) / alpha, two quotient bits per stage
module roc_div import roc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  comp_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output ratio_item_t out_item
);

    logic                   stg_valid_reg [DIV_STAGES];
    logic                   stg_ready     [DIV_STAGES];
    comp_item_t             stg_item_reg  [DIV_STAGES];
    logic [CHAN_W-1:0]      stg_rem_reg   [DIV_STAGES];
    logic [CHAN_W-1:0]      stg_quo_reg   [DIV_STAGES];
    logic [CHAN_W-1:0]      rem_next      [DIV_STAGES];
    logic [CHAN_W-1:0]      quo_next      [DIV_STAGES];

    // Partial remainder, quotient and divisor entering each stage
    logic [CHAN_W-1:0]      stg_rem_in    [DIV_STAGES];
    logic [CHAN_W-1:0]      stg_quo_in    [DIV_STAGES];
    logic [CHAN_W-1:0]      stg_dvs_in    [DIV_STAGES];

    // Ready chain
    always_comb
    begin
        stg_ready[DIV_STAGES-1] = !stg_valid_reg[DIV_STAGES-1] || out_ready;
        for (int i = DIV_STAGES - 2; i >= 0; i--)
            stg_ready[i] = !stg_valid_reg[i] || stg_ready[i+1];
    end
    assign in_ready = stg_ready[0];

    // Stage inputs: the first stage takes the incoming item
    always_comb
    begin
        stg_rem_in[0] = in_item.sa;
        stg_quo_in[0] = '0;
        stg_dvs_in[0] = in_item.alpha;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            stg_rem_in[i] = stg_rem_reg[i-1];
            stg_quo_in[i] = stg_quo_reg[i-1];
            stg_dvs_in[i] = stg_item_reg[i-1].alpha;
        end
    end

    // Quotient steps; the remainder stays below alpha so it fits 8 bits.
    // The low dividend bits are zero, so each step shifts in a zero.
    always_comb
    begin
        logic [CHAN_W-1:0] rem;
        logic [CHAN_W-1:0] quo;
        logic [CHAN_W-1:0] dvs;
        logic [CHAN_W:0]   r2;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            rem = stg_rem_in[i];
            quo = stg_quo_in[i];
            dvs = stg_dvs_in[i];
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++)
            begin
                r2 = {rem, 1'b0};
                if (r2 >= {1'b0, dvs})
                begin
                    r2  = r2 - {1'b0, dvs};
                    quo = {quo[CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    quo = {quo[CHAN_W-2:0], 1'b0};
                end
                rem = r2[CHAN_W-1:0];
            end
            rem_next[i] = rem;
            quo_next[i] = quo;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                stg_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (stg_ready[0])
                stg_valid_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                if (stg_ready[i])
                    stg_valid_reg[i] <= stg_valid_reg[i-1];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (stg_ready[0] && in_valid)
        begin
            stg_item_reg[0] <= in_item;
            stg_rem_reg[0]  <= rem_next[0];
            stg_quo_reg[0]  <= quo_next[0];
        end
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            if (stg_ready[i] && stg_valid_reg[i-1])
            begin
                stg_item_reg[i] <= stg_item_reg[i-1];
                stg_rem_reg[i]  <= rem_next[i];
                stg_quo_reg[i]  <= quo_next[i];
            end
        end
    end

    assign out_valid      = stg_valid_reg[DIV_STAGES-1];
    assign out_item.base  = stg_item_reg[DIV_STAGES-1];
    assign out_item.ratio = stg_quo_reg[DIV_STAGES-1];

endmodule

// ----- design/roc_blend.sv -----
// Channel products, then sums and case selection into the output register
module roc_blend import roc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ratio_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    logic              pa_valid_reg, pb_valid_reg;
    logic              pa_ready, pb_ready;

    blend_case_t       pa_case_reg, pa_case_next;
    rgb_t              pa_dest_reg, pa_src_reg;
    logic [7:0]        pa_alpha_reg;
    logic [2:0][15:0]  pa_dprod_reg, pa_sprod_reg;
    logic [2:0][15:0]  dprod_next, sprod_next;

    logic [2:0][7:0]   d_ch, s_ch, mix_ch;
    logic [8:0]        inv;
    logic [15:0]       sum;
    out_item_t         pb_item_reg, pb_item_next;

    assign pb_ready = !pb_valid_reg || out_ready;
    assign pa_ready = !pa_valid_reg || pb_ready;
    assign in_ready = pa_ready;

    // First stage: case decode and the six products
    always_comb
    begin
        d_ch = in_item.base.dest;
        s_ch = in_item.base.source;
        inv  = RATIO_ONE - {1'b0, in_item.ratio};
        for (int c = 0; c < 3; c++)
        begin
            dprod_next[c] = {8'd0, d_ch[c]} * {7'd0, inv};
            sprod_next[c] = {8'd0, s_ch[c]} * {8'd0, in_item.ratio};
        end
        if (in_item.base.alpha == 8'd0)
            pa_case_next = CASE_ZERO_ALPHA;
        else if (in_item.base.sa == in_item.base.alpha)
            pa_case_next = CASE_COPY_SRC;
        else if (in_item.base.sa == 8'd0)
            pa_case_next = CASE_KEEP_DEST;
        else
            pa_case_next = CASE_BLEND;
    end

    // Second stage: sums and selection
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum       = pa_dprod_reg[c] + pa_sprod_reg[c];
            mix_ch[c] = sum[15:8];
        end
        pb_item_next.alpha = pa_alpha_reg;
        case (pa_case_reg)
            CASE_ZERO_ALPHA:
            begin
                pb_item_next.color = pa_dest_reg;
                pb_item_next.alpha = 8'd0;
            end
            CASE_COPY_SRC:  pb_item_next.color = pa_src_reg;
            CASE_KEEP_DEST: pb_item_next.color = pa_dest_reg;
            CASE_BLEND:     pb_item_next.color = mix_ch;
            default:        pb_item_next.color = pa_dest_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_valid_reg <= 1'b0;
            pb_valid_reg <= 1'b0;
        end
        else
        begin
            if (pa_ready) pa_valid_reg <= in_valid;
            if (pb_ready) pb_valid_reg <= pa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pa_ready && in_valid)
        begin
            pa_case_reg  <= pa_case_next;
            pa_dest_reg  <= in_item.base.dest;
            pa_src_reg   <= in_item.base.source;
            pa_alpha_reg <= in_item.base.alpha;
            pa_dprod_reg <= dprod_next;
            pa_sprod_reg <= sprod_next;
        end
        if (pb_ready && pa_valid_reg)
            pb_item_reg <= pb_item_next;
    end

    assign out_valid = pb_valid_reg;
    assign out_item  = pb_item_reg;

endmodule

// ----- design/rgba_over_compositor_top.sv -----
// Channel    Dir  Payload                                       Transfer
// pix_in     in   dest_red/green/blue/alpha, source_red/...     valid && ready
// pix_out    out  result_red, result_green, result_blue, alpha  valid && ready
// cfg        in   cfg_index, cfg_data                           cfg_we
//
// One pixel per cycle sustained while pix_out is ready; registered stages: 4 alpha, 4 divider, 2 blend.
// The divider stages set the depth: two quotient bits per stage.
// Reset clears all valid bits and loads source_has_alpha = 1, global_opacity = 255.
// Backpressure ripples through the stages; bubbles are squeezed out on a stall.
module rgba_over_compositor_top import roc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    roc_in_if.sink                 pix_in,
    roc_out_if.source              pix_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        cfg_has_alpha_reg;
    logic [7:0]  cfg_opacity_reg;
    cfg_t        cfg;

    in_item_t    in_item;
    logic        a_valid, a_ready;
    comp_item_t  a_item;
    logic        d_valid, d_ready;
    ratio_item_t d_item;
    out_item_t   o_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_has_alpha_reg <= 1'b1;
            cfg_opacity_reg   <= OPAQUE_ALPHA;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_HAS_ALPHA: cfg_has_alpha_reg <= cfg_data[0];
                CFG_GLOBAL_OPACITY:   cfg_opacity_reg   <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    assign cfg.has_alpha = cfg_has_alpha_reg;
    assign cfg.opacity   = cfg_opacity_reg;

    assign in_item.dest.red     = pix_in.dest_red;
    assign in_item.dest.green   = pix_in.dest_green;
    assign in_item.dest.blue    = pix_in.dest_blue;
    assign in_item.dest_alpha   = pix_in.dest_alpha;
    assign in_item.source.red   = pix_in.source_red;
    assign in_item.source.green = pix_in.source_green;
    assign in_item.source.blue  = pix_in.source_blue;
    assign in_item.source_alpha = pix_in.source_alpha;

    roc_alpha u_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .in_item   (in_item),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_item  (a_item)
    );

    roc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_item   (a_item),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_item  (d_item)
    );

    roc_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_item   (d_item),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_item  (o_item)
    );

    assign pix_out.result_red   = o_item.color.red;
    assign pix_out.result_green = o_item.color.green;
    assign pix_out.result_blue  = o_item.color.blue;
    assign pix_out.result_alpha = o_item.alpha;

endmodule

// ----- design/roc_checker.sv -----
// Port-level checks on the compositor
module roc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_data
);

    // Output valid holds until transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before transfer");

    // Output payload holds while stalled
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output payload changed while stalled");

    // With the output free, the whole pipe can move, so input must be ready
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready || !out_valid |-> in_ready)
        else $error("input stalled while output side is free");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind rgba_over_compositor_top roc_checker u_roc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_data  ({pix_out.result_red, pix_out.result_green,
                 pix_out.result_blue, pix_out.result_alpha})
);

// ----- dv/rgba_over_compositor_checker.sv -----
`timescale 1ns / 1ps

module rgba_over_compositor_checker import roc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    roc_in_if                      pix_in,
    roc_out_if                     pix_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending
);

    // Shadow copy of the configuration registers
    logic              has_alpha;
    logic [CHAN_W-1:0] opacity;

    // Composited pixels still owed by the block, oldest first
    out_item_t expected_pixels[$];
    int        pixels_seen;

    // Rounded a*b/255
    function automatic logic [CHAN_W-1:0] scale_div255(input logic [CHAN_W-1:0] a,
                                                       input logic [CHAN_W-1:0] b);
        logic [16:0] t;
        t = a * b + ROUND_HALF;
        return 8'(((t >> 8) + t) >> 8);
    endfunction

    // 8.8 blend of one color channel, truncated
    function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] d,
                                                      input logic [CHAN_W-1:0] s,
                                                      input logic [CHAN_W-1:0] ratio);
        logic [8:0]  inv;
        logic [16:0] acc;
        inv = RATIO_ONE - {1'b0, ratio};
        acc = d * inv + s * ratio;
        return acc[15:8];
    endfunction

    // Straight-alpha source-over-destination for one pixel pair
    function automatic out_item_t composite_over(input in_item_t px,
                                                 input logic use_alpha,
                                                 input logic [CHAN_W-1:0] op);
        logic [CHAN_W-1:0] sa;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] ratio;
        out_item_t         r;
        sa = use_alpha ? px.source_alpha : OPAQUE_ALPHA;
        if (op != OPAQUE_ALPHA)
            sa = scale_div255(sa, op);
        alpha = sa + scale_div255(px.dest_alpha, OPAQUE_ALPHA - sa);

        r.color = px.dest;
        r.alpha = alpha;
        if (alpha == '0)
            r.alpha = '0;
        else if (sa == alpha)
            r.color = px.source;
        else if (sa != '0)
        begin
            // sa < alpha here, so the ratio stays below one
            ratio = 8'({sa, 8'd0} / alpha);
            r.color.red   = mix_channel(px.dest.red,   px.source.red,   ratio);
            r.color.green = mix_channel(px.dest.green, px.source.green, ratio);
            r.color.blue  = mix_channel(px.dest.blue,  px.source.blue,  ratio);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Watch both channels and the register port at every rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        in_item_t  px;
        out_item_t got;
        out_item_t want;
        string     names[4];
        names = '{"red", "green", "blue", "alpha"};
        if (!rst_n)
        begin
            has_alpha   = 1'b1;
            opacity     = OPAQUE_ALPHA;
            mismatches  = 0;
            pixels_seen = 0;
            expected_pixels.delete();
        end
        else
        begin
            // Input transfer: predict with the registers as they stand
            if (pix_in.valid && pix_in.ready)
            begin
                px.dest.red     = pix_in.dest_red;
                px.dest.green   = pix_in.dest_green;
                px.dest.blue    = pix_in.dest_blue;
                px.dest_alpha   = pix_in.dest_alpha;
                px.source.red   = pix_in.source_red;
                px.source.green = pix_in.source_green;
                px.source.blue  = pix_in.source_blue;
                px.source_alpha = pix_in.source_alpha;
                expected_pixels.push_back(composite_over(px, has_alpha, opacity));
            end

            // Output transfer: compare against the oldest prediction
            if (pix_out.valid && pix_out.ready)
            begin
                got.color.red   = pix_out.result_red;
                got.color.green = pix_out.result_green;
                got.color.blue  = pix_out.result_blue;
                got.alpha       = pix_out.result_alpha;
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected pixel %0d: %h", pixels_seen, got));
                else
                begin
                    want = expected_pixels.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got[31-8*k -: 8] !== want[31-8*k -: 8])
                            report_mismatch($sformatf("pixel %0d %s: got %0d, expected %0d",
                                pixels_seen, names[k], got[31-8*k -: 8],
                                want[31-8*k -: 8]));
                end
                pixels_seen++;
            end

            // Register writes take effect for the next transfer
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SOURCE_HAS_ALPHA: has_alpha = cfg_data[0];
                    CFG_GLOBAL_OPACITY:   opacity   = cfg_data;
                    default:              ;
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ----- dv/rgba_over_compositor_top_tb.sv -----
`timescale 1ns / 1ps

module rgba_over_compositor_top_tb;
    import roc_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 240;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     pending;

    // Idle rates in percent, changed per phase
    int   in_gap_pct    = 0;
    int   out_stall_pct = 0;
    logic hold_request  = 1'b0;

    roc_in_if  pix_in ();
    roc_out_if pix_out ();

    rgba_over_compositor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rgba_over_compositor_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .pix_out    (pix_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold when asked
    initial
    begin
        pix_out.ready = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                pix_out.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            else if ($urandom_range(0, 99) < out_stall_pct)
            begin
                pix_out.ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            else
            begin
                pix_out.ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    function automatic in_item_t pixel(input logic [7:0] dr, dg, db, da,
                                       input logic [7:0] sr, sg, sb, sa);
        in_item_t px;
        px.dest         = '{red: dr, green: dg, blue: db};
        px.dest_alpha   = da;
        px.source       = '{red: sr, green: sg, blue: sb};
        px.source_alpha = sa;
        return px;
    endfunction

    // Alpha values leaning toward the edges of the range
    function automatic logic [7:0] rand_alpha();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic in_item_t random_pixel();
        return pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), rand_alpha(),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), rand_alpha());
    endfunction

    // One input transfer, with an optional gap ahead of it; called at a falling edge
    task automatic send_pixel(input in_item_t px);
        if ($urandom_range(0, 99) < in_gap_pct)
        begin
            pix_in.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        pix_in.dest_red     = px.dest.red;
        pix_in.dest_green   = px.dest.green;
        pix_in.dest_blue    = px.dest.blue;
        pix_in.dest_alpha   = px.dest_alpha;
        pix_in.source_red   = px.source.red;
        pix_in.source_green = px.source.green;
        pix_in.source_blue  = px.source.blue;
        pix_in.source_alpha = px.source_alpha;
        pix_in.valid        = 1'b1;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait until every composited pixel is back
    task automatic drain();
        pix_in.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Reconfigure while idle; the alpha flag rides on bit 0 of a noisy byte
    task automatic configure(input logic use_alpha, input logic [7:0] op);
        logic [7:0] flag_word;
        flag_word    = 8'($urandom_range(0, 255));
        flag_word[0] = use_alpha;
        drain();
        write_reg(CFG_SOURCE_HAS_ALPHA, flag_word);
        write_reg(CFG_GLOBAL_OPACITY, op);
    endtask

    task automatic run_phase(input logic use_alpha, input logic [7:0] op,
                             input int gap_pct, input int stall_pct, input bit long_hold);
        configure(use_alpha, op);
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            // Long receiver hold while the sender keeps offering
            if (long_hold && i == 20)
                hold_request = 1'b1;
            send_pixel(random_pixel());
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_SOURCE_HAS_ALPHA;
        cfg_data            = '0;
        pix_in.valid        = 1'b0;
        pix_in.dest_red     = '0;
        pix_in.dest_green   = '0;
        pix_in.dest_blue    = '0;
        pix_in.dest_alpha   = '0;
        pix_in.source_red   = '0;
        pix_in.source_green = '0;
        pix_in.source_blue  = '0;
        pix_in.source_alpha = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset configuration, source alpha used, no opacity scaling
        send_pixel(pixel(0, 0, 0, 0, 0, 0, 0, 0));                // both clear
        send_pixel(pixel(255, 255, 255, 255, 255, 255, 255, 255));
        send_pixel(pixel(10, 20, 30, 0, 200, 100, 50, 0));        // zero out alpha keeps color
        send_pixel(pixel(12, 34, 56, 200, 1, 2, 3, 0));           // transparent source
        send_pixel(pixel(90, 80, 70, 0, 5, 6, 7, 128));           // source dominates
        send_pixel(pixel(40, 50, 60, 255, 220, 210, 200, 128));   // blend
        send_pixel(pixel(200, 100, 0, 100, 0, 100, 200, 1));
        send_pixel(pixel(0, 0, 0, 255, 255, 255, 255, 254));
        send_pixel(pixel(255, 255, 255, 128, 0, 0, 0, 128));
        send_pixel(pixel(0, 0, 0, 255, 255, 255, 255, 64));
        send_pixel(pixel(1, 2, 3, 7, 251, 252, 253, 255));        // opaque source
        send_pixel(pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));

        // Source treated as opaque: the alpha field must not matter
        configure(1'b0, 8'd255);
        send_pixel(pixel(11, 22, 33, 44, 55, 66, 77, 0));
        send_pixel(pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));

        // Opaque source scaled by half opacity
        configure(1'b0, 8'd128);
        send_pixel(pixel(255, 0, 128, 255, 0, 255, 127, 9));
        send_pixel(pixel(3, 200, 90, 0, 240, 10, 60, 200));

        // Zero opacity wipes the source out
        configure(1'b1, 8'd0);
        send_pixel(pixel(70, 80, 90, 0, 1, 2, 3, 255));
        send_pixel(pixel(70, 80, 90, 150, 1, 2, 3, 255));

        configure(1'b1, 8'd128);
        send_pixel(pixel(100, 150, 200, 255, 250, 50, 0, 255));
        send_pixel(pixel(255, 255, 255, 30, 0, 0, 0, 200));
        send_pixel(pixel(0, 0, 0, 0, 255, 255, 255, 77));

        configure(1'b1, 8'd1);
        send_pixel(pixel(10, 10, 10, 0, 250, 250, 250, 255));
        send_pixel(pixel(10, 10, 10, 255, 250, 250, 250, 255));

        // Random phases over several register settings
        run_phase(1'b1, 8'd255, 10, 8, 1'b0);
        run_phase(1'b0, 8'd255, 0, 12, 1'b0);
        run_phase(1'b1, 8'd254, 25, 0, 1'b0);
        run_phase(1'b1, 8'($urandom_range(0, 255)), 0, 0, 1'b0);
        run_phase(1'b0, 8'($urandom_range(0, 255)), 40, 30, 1'b0);
        run_phase(1'b1, 8'd1, 0, 5, 1'b1);
        run_phase(1'b1, 8'd0, 15, 15, 1'b0);
        // Last stretch runs at full rate on both sides
        run_phase(1'b1, 8'($urandom_range(1, 254)), 0, 0, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/roc_pkg.sv
design/roc_if.sv
design/roc_alpha.sv
design/roc_div.sv
design/roc_blend.sv
design/rgba_over_compositor_top.sv
design/roc_checker.sv
dv/rgba_over_compositor_checker.sv
dv/rgba_over_compositor_top_tb.sv
